FILE: sv/patbl_pkg.sv
// Shared types, codes and constants for the per-address token bucket limiter.
// No dependencies; every other file imports this package.
package patbl_pkg;

   localparam int unsigned DEFAULT_ENTRIES = 256;

   // request and response codes
   localparam logic [1:0] OP_ACQUIRE = 2'd0;
   localparam logic [1:0] OP_ALLOW   = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   localparam logic [1:0] RSP_GRANTED   = 2'd0;
   localparam logic [1:0] RSP_NO_TOKENS = 2'd1;
   localparam logic [1:0] RSP_UNTRACKED = 2'd2;
   localparam logic [1:0] RSP_FULL      = 2'd3;

   // configuration register indexes
   localparam logic CSR_BURST_SIZE        = 1'b0;
   localparam logic CSR_TOKENS_PER_SECOND = 1'b1;

   localparam int unsigned TOKEN_W   = 16;
   localparam int unsigned TIME_W    = 48;
   localparam int unsigned LIVE_W    = 16;
   localparam int unsigned RATE_W    = 20;
   localparam int unsigned CSR_W     = 20;

   localparam logic [TOKEN_W-1:0] BURST_RESET = 16'd64;
   localparam logic [RATE_W-1:0]  RATE_RESET  = 20'd10;

   // refill arithmetic: refill = min(elapsed * rate / 1000, 2^17)
   localparam int unsigned MS_PER_SEC  = 1000;
   localparam int unsigned REFILL_W    = 18;
   localparam int unsigned QUO_W       = 17;
   localparam int unsigned ELAPSED_W   = 27;
   localparam int unsigned PROD_W      = ELAPSED_W + RATE_W;
   localparam int unsigned RECIP_SHIFT = 37;
   localparam int unsigned RECIP_W     = 28;
   localparam int unsigned RECIP_PROD_W = ELAPSED_W + RECIP_W;
   localparam longint unsigned REFILL_CAP_VAL = 64'd1 << QUO_W;
   localparam longint unsigned SAT_PRODUCT_VAL = REFILL_CAP_VAL * MS_PER_SEC;
   localparam longint unsigned RECIP_VAL =
      ((64'd1 << RECIP_SHIFT) + MS_PER_SEC - 1) / MS_PER_SEC;
   localparam logic [REFILL_W-1:0] REFILL_CAP  = REFILL_W'(REFILL_CAP_VAL);
   localparam logic [PROD_W-1:0]   SAT_PRODUCT = PROD_W'(SAT_PRODUCT_VAL);
   localparam logic [RECIP_W-1:0]  RECIP       = RECIP_W'(RECIP_VAL);

   typedef struct packed {
      logic [1:0]        req_type;
      logic [63:0]       ip_high;
      logic [63:0]       ip_low;
      logic [TIME_W-1:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [TOKEN_W-1:0] tokens_left;
   } rsp_payload_type;

   typedef struct packed {
      logic [TOKEN_W-1:0] tokens;
      logic [TIME_W-1:0]  last_ms;
      logic [LIVE_W-1:0]  live;
   } data_rec_type;

   typedef enum logic [1:0] {LK_NONE, LK_UNLINK, LK_PUSH, LK_CLEAR} link_op_type;
   typedef enum logic [2:0] {DW_NONE, DW_NEW, DW_ACQ, DW_REL, DW_ALLOW} data_op_type;
   typedef enum logic [1:0] {RES_NONE, RES_MISS, RES_FULL} res_op_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_HIT, S_MISS, S_WALK_RD, S_WALK_CK, S_UNLINK,
      S_PUSH_A, S_PUSH_B, S_REFILL_A, S_REFILL_B, S_UPDATE, S_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic        ld_req;
      logic        scan_clr;
      logic        scan_issue;
      logic        cap;
      logic        alloc_free;
      logic        walk_start;
      logic        walk_read;
      logic        walk_step;
      link_op_type link_op;
      data_op_type data_op;
      res_op_type  res_op;
      logic        rsp_load;
   } patbl_cmd_type;

   typedef struct packed {
      logic [1:0] new_op;
      logic [1:0] op;
      logic       hit;
      logic       scan_done;
      logic       is_head;
      logic       table_full;
      logic       walk_none;
      logic       walk_live;
      logic       rsp_free;
   } patbl_status_type;

endpackage

FILE: sv/patbl_ctrl.sv
// Sequencer for lookup, eviction walk, recency list update and bucket update.
// Depends on patbl_pkg; drives patbl_dpath through command/status structs.
module patbl_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  patbl_pkg::patbl_status_type stat,
   output patbl_pkg::patbl_cmd_type    cmd
);
   import patbl_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           new_ff, new_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         new_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         new_ff   <= new_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      new_in   = new_ff;
      case (state_ff)
         S_IDLE: begin
            new_in = 1'b0;
            if (req_valid) begin
               if (stat.new_op inside {OP_ACQUIRE, OP_ALLOW, OP_RELEASE}) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_SCAN: begin
            if (stat.hit) begin
               state_in = S_HIT;
            end else if (stat.scan_done) begin
               state_in = S_MISS;
            end
         end
         S_HIT: begin
            case (stat.op)
               OP_ACQUIRE: state_in = stat.is_head ? S_UPDATE : S_UNLINK;
               OP_ALLOW:   state_in = stat.is_head ? S_REFILL_A : S_UNLINK;
               default:    state_in = S_UPDATE;
            endcase
         end
         S_MISS: begin
            if (stat.op == OP_ACQUIRE) begin
               if (!stat.table_full) begin
                  new_in   = 1'b1;
                  state_in = S_PUSH_A;
               end else begin
                  state_in = S_WALK_RD;
               end
            end else begin
               state_in = S_RESP;
            end
         end
         S_WALK_RD: state_in = stat.walk_none ? S_RESP : S_WALK_CK;
         S_WALK_CK: begin
            if (stat.walk_live) begin
               state_in = S_WALK_RD;
            end else begin
               new_in   = 1'b1;
               state_in = S_UNLINK;
            end
         end
         S_UNLINK: state_in = S_PUSH_A;
         S_PUSH_A: state_in = S_PUSH_B;
         S_PUSH_B: begin
            if (new_ff) begin
               state_in = S_RESP;
            end else if (stat.op == OP_ALLOW) begin
               state_in = S_REFILL_A;
            end else begin
               state_in = S_UPDATE;
            end
         end
         S_REFILL_A: state_in = S_REFILL_B;
         S_REFILL_B: state_in = S_UPDATE;
         S_UPDATE:   state_in = S_RESP;
         S_RESP: begin
            if (stat.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.ld_req   = req_valid;
            cmd.scan_clr = 1'b1;
            cmd.res_op   = req_valid ? RES_MISS : RES_NONE;
         end
         S_SCAN: begin
            cmd.cap        = stat.hit;
            cmd.scan_issue = !stat.hit && !stat.scan_done;
         end
         S_MISS: begin
            cmd.alloc_free = (stat.op == OP_ACQUIRE) && !stat.table_full;
            cmd.walk_start = (stat.op == OP_ACQUIRE) && stat.table_full;
         end
         S_WALK_RD: begin
            cmd.walk_read = !stat.walk_none;
            cmd.res_op    = stat.walk_none ? RES_FULL : RES_NONE;
         end
         S_WALK_CK: begin
            cmd.walk_step = stat.walk_live;
            cmd.cap       = !stat.walk_live;
         end
         S_UNLINK: cmd.link_op = LK_UNLINK;
         S_PUSH_A: cmd.link_op = LK_PUSH;
         S_PUSH_B: begin
            cmd.link_op = LK_CLEAR;
            cmd.data_op = new_ff ? DW_NEW : DW_NONE;
         end
         S_UPDATE: begin
            case (stat.op)
               OP_ACQUIRE: cmd.data_op = DW_ACQ;
               OP_ALLOW:   cmd.data_op = DW_ALLOW;
               default:    cmd.data_op = DW_REL;
            endcase
         end
         S_RESP: cmd.rsp_load = stat.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

FILE: sv/patbl_dpath.sv
// Entry tables, recency list pointers, refill arithmetic and result register.
// Depends on patbl_pkg; commanded by patbl_ctrl.
module patbl_dpath #(
   parameter int unsigned ENTRIES = patbl_pkg::DEFAULT_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  patbl_pkg::req_payload_type    req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output patbl_pkg::rsp_payload_type    rsp_payload,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [patbl_pkg::CSR_W-1:0]   csr_wdata,
   input  patbl_pkg::patbl_cmd_type      cmd,
   output patbl_pkg::patbl_status_type   stat
);
   import patbl_pkg::*;

   localparam int unsigned IW = $clog2(ENTRIES);
   localparam int unsigned LW = IW + 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam logic [LW-1:0] NONE_LINK = LW'(ENTRIES);
   localparam logic [CW-1:0] FULL_FILL = CW'(ENTRIES);

   // tables
   logic [63:0]   key_hi_mem [ENTRIES];
   logic [63:0]   key_lo_mem [ENTRIES];
   data_rec_type  data_mem   [ENTRIES];
   logic [LW-1:0] prev_mem   [ENTRIES];
   logic [LW-1:0] next_mem   [ENTRIES];

   logic [63:0]   rd_key_hi_ff, rd_key_lo_ff;
   data_rec_type  rd_data_ff;
   logic [LW-1:0] rd_prev_ff, rd_next_ff;
   logic [IW-1:0] rdq_ff;

   logic [TOKEN_W-1:0] burst_ff;
   logic [RATE_W-1:0]  rate_ff;

   req_payload_type req_ff;
   data_rec_type    cur_ff;
   logic [LW-1:0]   prev_ff, next_ff;
   logic [IW-1:0]   idx_ff;
   logic [LW-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]   fill_ff, scan_ff;
   logic            pend_ff, free_ff;
   logic [LW-1:0]   walk_ff;

   logic [ELAPSED_W-1:0] el_ff;
   logic                 el_big_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic                 sat1_ff;
   logic [QUO_W-1:0]     quo_ff;
   logic                 sat2_ff;

   rsp_payload_type res_ff, res_in, rsp_ff;
   logic            rsp_valid_ff;

   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          key_we, data_we, fill_inc;
   data_rec_type  data_wd;
   logic          prev_we, next_we;
   logic [IW-1:0] prev_wa, next_wa;
   logic [LW-1:0] prev_wd, next_wd;

   logic [TIME_W-1:0]       diff;
   logic [PROD_W-1:0]       prod_in;
   logic [RECIP_PROD_W-1:0] recip_prod;
   logic [REFILL_W-1:0]     refill, sum;
   logic                    some_refill;
   logic [TOKEN_W-1:0]      filled, new_tok;

   assign rd_en   = cmd.scan_issue || cmd.walk_read;
   assign rd_addr = cmd.walk_read ? walk_ff[IW-1:0] : scan_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_hi_ff <= key_hi_mem[rd_addr];
         rd_key_lo_ff <= key_lo_mem[rd_addr];
         rd_data_ff   <= data_mem[rd_addr];
         rd_prev_ff   <= prev_mem[rd_addr];
         rd_next_ff   <= next_mem[rd_addr];
         rdq_ff       <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_hi_mem[idx_ff] <= req_ff.ip_high;
         key_lo_mem[idx_ff] <= req_ff.ip_low;
      end
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[idx_ff] <= data_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff <= BURST_RESET;
         rate_ff  <= RATE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BURST_SIZE:        burst_ff <= csr_wdata[TOKEN_W-1:0];
            CSR_TOKENS_PER_SECOND: rate_ff  <= csr_wdata[RATE_W-1:0];
            default:               burst_ff <= burst_ff;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.ld_req) begin
         req_ff <= req_payload;
      end
      if (cmd.cap) begin
         idx_ff  <= rdq_ff;
         cur_ff  <= rd_data_ff;
         prev_ff <= rd_prev_ff;
         next_ff <= rd_next_ff;
      end else if (cmd.alloc_free) begin
         idx_ff <= fill_ff[IW-1:0];
      end
      if (cmd.walk_start) begin
         walk_ff <= tail_ff;
      end else if (cmd.walk_step) begin
         walk_ff <= rd_prev_ff;
      end
      if (data_op_type'(cmd.data_op) != DW_NONE || cmd.res_op != RES_NONE) begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= NONE_LINK;
         tail_ff <= NONE_LINK;
         fill_ff <= '0;
         scan_ff <= '0;
         pend_ff <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         pend_ff <= cmd.scan_issue;
         if (fill_inc) begin
            fill_ff <= fill_ff + CW'(1);
         end
         if (cmd.scan_clr) begin
            scan_ff <= '0;
         end else if (cmd.scan_issue) begin
            scan_ff <= scan_ff + CW'(1);
         end
         if (cmd.alloc_free) begin
            free_ff <= 1'b1;
         end else if (cmd.cap) begin
            free_ff <= 1'b0;
         end
      end
   end

   // recency list writes
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      prev_we = 1'b0;
      next_we = 1'b0;
      prev_wa = idx_ff;
      next_wa = idx_ff;
      prev_wd = NONE_LINK;
      next_wd = NONE_LINK;
      case (cmd.link_op)
         LK_UNLINK: begin
            next_we = prev_ff != NONE_LINK;
            next_wa = prev_ff[IW-1:0];
            next_wd = next_ff;
            prev_we = next_ff != NONE_LINK;
            prev_wa = next_ff[IW-1:0];
            prev_wd = prev_ff;
            if (prev_ff == NONE_LINK) begin
               head_in = next_ff;
            end
            if (next_ff == NONE_LINK) begin
               tail_in = prev_ff;
            end
         end
         LK_PUSH: begin
            next_we = 1'b1;
            next_wd = head_ff;
            prev_we = head_ff != NONE_LINK;
            prev_wa = head_ff[IW-1:0];
            prev_wd = LW'(idx_ff);
            head_in = LW'(idx_ff);
            if (tail_ff == NONE_LINK) begin
               tail_in = LW'(idx_ff);
            end
         end
         LK_CLEAR: prev_we = 1'b1;
         default: prev_we = 1'b0;
      endcase
   end

   // refill pipeline, free running off the captured entry
   assign diff    = req_ff.now_ms - cur_ff.last_ms;
   assign prod_in = el_ff * rate_ff;
   assign recip_prod = prod_ff[ELAPSED_W-1:0] * RECIP;

   always_ff @(posedge clock) begin
      if (req_ff.now_ms > cur_ff.last_ms) begin
         el_ff     <= diff[ELAPSED_W-1:0];
         el_big_ff <= |diff[TIME_W-1:ELAPSED_W];
      end else begin
         el_ff     <= '0;
         el_big_ff <= 1'b0;
      end
      prod_ff <= prod_in;
      sat1_ff <= el_big_ff && (rate_ff != '0);
      quo_ff  <= recip_prod[RECIP_SHIFT +: QUO_W];
      sat2_ff <= sat1_ff || (prod_ff >= SAT_PRODUCT);
   end

   assign refill      = sat2_ff ? REFILL_CAP : REFILL_W'(quo_ff);
   assign some_refill = sat2_ff || (quo_ff != '0);
   assign sum         = REFILL_W'(cur_ff.tokens) + refill;
   assign filled      = (sum > REFILL_W'(burst_ff)) ? burst_ff : sum[TOKEN_W-1:0];
   assign new_tok     = some_refill ? filled : cur_ff.tokens;

   // entry data writes and result
   always_comb begin
      key_we   = 1'b0;
      data_we  = 1'b0;
      fill_inc = 1'b0;
      data_wd  = cur_ff;
      res_in   = res_ff;
      case (cmd.res_op)
         RES_MISS: res_in = '{status: RSP_UNTRACKED, tokens_left: '0};
         RES_FULL: res_in = '{status: RSP_FULL, tokens_left: '0};
         default:  res_in = res_ff;
      endcase
      case (cmd.data_op)
         DW_NEW: begin
            key_we   = 1'b1;
            data_we  = 1'b1;
            fill_inc = free_ff;
            data_wd  = '{tokens: burst_ff, last_ms: '0, live: LIVE_W'(1)};
            res_in   = '{status: RSP_GRANTED, tokens_left: burst_ff};
         end
         DW_ACQ: begin
            data_we = 1'b1;
            if (cur_ff.live != '1) begin
               data_wd.live = cur_ff.live + LIVE_W'(1);
            end
            res_in = '{status: RSP_GRANTED, tokens_left: cur_ff.tokens};
         end
         DW_REL: begin
            data_we = 1'b1;
            if (cur_ff.live != '0) begin
               data_wd.live = cur_ff.live - LIVE_W'(1);
            end
            res_in = '{status: RSP_GRANTED, tokens_left: cur_ff.tokens};
         end
         DW_ALLOW: begin
            data_we = 1'b1;
            if (some_refill) begin
               data_wd.last_ms = req_ff.now_ms;
            end
            if (new_tok != '0) begin
               data_wd.tokens = new_tok - TOKEN_W'(1);
               res_in = '{status: RSP_GRANTED, tokens_left: new_tok - TOKEN_W'(1)};
            end else begin
               data_wd.tokens = new_tok;
               res_in = '{status: RSP_NO_TOKENS, tokens_left: new_tok};
            end
         end
         default: data_we = 1'b0;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign stat.new_op     = req_payload.req_type;
   assign stat.op         = req_ff.req_type;
   assign stat.hit        = pend_ff && (rd_key_hi_ff == req_ff.ip_high)
                            && (rd_key_lo_ff == req_ff.ip_low);
   assign stat.scan_done  = scan_ff == fill_ff;
   assign stat.is_head    = LW'(idx_ff) == head_ff;
   assign stat.table_full = fill_ff == FULL_FILL;
   assign stat.walk_none  = walk_ff == NONE_LINK;
   assign stat.walk_live  = rd_data_ff.live != '0;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule

FILE: sv/per_address_token_bucket_limiter.sv
// Per-address token bucket limiter: top level joining controller and datapath.
// Depends on patbl_pkg, patbl_ctrl and patbl_dpath.
//
//   channel  ports                            transfer when
//   request  req_valid/req_ready/req_payload  req_valid & req_ready
//   result   rsp_valid/rsp_ready/rsp_payload  rsp_valid & rsp_ready
//   config   csr_we/csr_index/csr_wdata       csr_we
//
// One request at a time. The lookup scans the filled entries one per cycle
// through the table read port, then list and bucket updates follow on a hit
// and list and entry writes for a new entry. A full-table acquire walks the
// recency list from the tail, reading and checking each entry visited, then
// relinks the victim.
// Reset empties the table at once. The output register lets a new request in
// while the previous result waits for rsp_ready.
module per_address_token_bucket_limiter #(
   parameter int unsigned ENTRIES = patbl_pkg::DEFAULT_ENTRIES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  patbl_pkg::req_payload_type  req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output patbl_pkg::rsp_payload_type  rsp_payload,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [patbl_pkg::CSR_W-1:0] csr_wdata
);
   import patbl_pkg::*;

   patbl_cmd_type    cmd;
   patbl_status_type stat;

   patbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   patbl_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

FILE: sv/patbl_checker.sv
// Port-level checks for the limiter, attached to the top level by bind.
// Depends on patbl_pkg and per_address_token_bucket_limiter.
module patbl_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input patbl_pkg::rsp_payload_type rsp_payload
);
   import patbl_pkg::*;

   a_rsp_hold: assert property (@(posedge clock)
      (!reset && rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("result dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock)
      (!reset && req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in progress");

   a_empty_tokens: assert property (@(posedge clock)
      (rsp_valid && (rsp_payload.status == RSP_NO_TOKENS
                     || rsp_payload.status == RSP_UNTRACKED
                     || rsp_payload.status == RSP_FULL))
      |-> (rsp_payload.tokens_left == '0))
      else $error("nonzero tokens reported without a grant");

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind per_address_token_bucket_limiter patbl_checker u_patbl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

FILE: tb/per_address_token_bucket_limiter_test.sv
// Self-checking testbench for per_address_token_bucket_limiter: directed table, then random
// acquire/allow/release traffic checked against an in-bench table and token bucket predictor.
// Depends on patbl_pkg and the per_address_token_bucket_limiter RTL.
module per_address_token_bucket_limiter_test;
   import patbl_pkg::*;

   localparam int ENT = DEFAULT_ENTRIES;
   localparam int NO_LINK = ENT;
   localparam int POOL = 320;
   localparam int WATCHDOG = 5000;
   localparam int LONG_HOLD = 300;
   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam longint unsigned MS_MAX = 64'hFFFF_FFFF_FFFF;

   typedef struct {
      bit                  is_csr;
      logic                csr_idx;
      logic [CSR_W-1:0]    csr_val;
      logic [1:0]          op;
      int                  addr;
      longint unsigned     ms;
      logic [1:0]          st;
      logic [TOKEN_W-1:0]  tk;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_payload_type rsp_payload;
   logic csr_we = 0;
   logic csr_index = 0;
   logic [CSR_W-1:0] csr_wdata = '0;

   per_address_token_bucket_limiter uut (.*);

   always #10 clock = ~clock;

   // predictor state
   int unsigned     burst_cap = 64;
   int unsigned     fill_rate = 10;
   bit              slot_used [ENT];
   logic [63:0]     slot_hi [ENT];
   logic [63:0]     slot_lo [ENT];
   int unsigned     slot_tokens [ENT];
   longint unsigned slot_last [ENT];
   int unsigned     slot_live [ENT];
   int              slot_prev [ENT];
   int              slot_next [ENT];
   int              mru_head = NO_LINK;
   int              lru_tail = NO_LINK;

   rsp_payload_type pending_rsp [$];
   logic [63:0]     addr_hi [POOL];
   logic [63:0]     addr_lo [POOL];
   longint unsigned cur_ms = 0;
   int  errors = 0;
   bit  idle_on = 1;
   bit  long_hold_go = 0;
   bit  long_hold_used = 0;
   int  hold_left = 0;
   int  stall_left = 0;
   int  quiet_cycles = 0;
   row_type rows [$];

   function automatic void unlink_slot(int i);
      int p, n;
      p = slot_prev[i];
      n = slot_next[i];
      if (p < ENT) slot_next[p] = n; else mru_head = n;
      if (n < ENT) slot_prev[n] = p; else lru_tail = p;
      slot_prev[i] = NO_LINK;
      slot_next[i] = NO_LINK;
   endfunction

   function automatic void push_mru(int i);
      slot_prev[i] = NO_LINK;
      slot_next[i] = mru_head;
      if (mru_head < ENT) slot_prev[mru_head] = i;
      mru_head = i;
      if (lru_tail >= ENT) lru_tail = i;
   endfunction

   function automatic void touch_slot(int i);
      if (i != mru_head) begin
         unlink_slot(i);
         push_mru(i);
      end
   endfunction

   function automatic rsp_payload_type limiter_outcome(req_payload_type q);
      rsp_payload_type r;
      int i, j;
      longint unsigned now, elapsed, sum;
      bit [127:0] refill;
      r.status = RSP_UNTRACKED;
      r.tokens_left = '0;
      now = q.now_ms;
      i = NO_LINK;
      for (int k = 0; k < ENT; k++)
         if (i == NO_LINK && slot_used[k] && slot_hi[k] == q.ip_high && slot_lo[k] == q.ip_low)
            i = k;
      case (q.req_type)
         OP_ACQUIRE: begin
            if (i == NO_LINK) begin
               j = 0;
               while (j < ENT && slot_used[j]) j++;
               if (j >= ENT) begin
                  j = lru_tail;
                  while (j < ENT && slot_live[j] > 0) j = slot_prev[j];
                  if (j < ENT) unlink_slot(j);
               end
               if (j < ENT) begin
                  slot_used[j] = 1;
                  slot_hi[j] = q.ip_high;
                  slot_lo[j] = q.ip_low;
                  slot_tokens[j] = burst_cap;
                  slot_last[j] = 0;
                  slot_live[j] = 0;
                  push_mru(j);
               end
               i = j;
            end else begin
               touch_slot(i);
            end
            if (i < ENT) begin
               if (slot_live[i] < 16'hFFFF) slot_live[i]++;
               r.status = RSP_GRANTED;
               r.tokens_left = TOKEN_W'(slot_tokens[i]);
            end else begin
               r.status = RSP_FULL;
            end
         end
         OP_ALLOW: begin
            if (i < ENT) begin
               touch_slot(i);
               elapsed = (now > slot_last[i]) ? now - slot_last[i] : 0;
               refill = (128'(elapsed) * 128'(fill_rate)) / 1000;
               if (refill > 0) begin
                  if (refill > 128'h20000) refill = 128'h20000;
                  sum = slot_tokens[i] + longint'(refill);
                  slot_last[i] = now;
                  slot_tokens[i] = (sum > burst_cap) ? burst_cap : int'(sum);
               end
               if (slot_tokens[i] > 0) begin
                  slot_tokens[i]--;
                  r.status = RSP_GRANTED;
               end else begin
                  r.status = RSP_NO_TOKENS;
               end
               r.tokens_left = TOKEN_W'(slot_tokens[i]);
            end
         end
         OP_RELEASE: begin
            if (i < ENT) begin
               if (slot_live[i] > 0) slot_live[i]--;
               r.status = RSP_GRANTED;
               r.tokens_left = TOKEN_W'(slot_tokens[i]);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // receiver: random stalls, one long hold on request, result checking
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected transfer status=%0d tokens=%0d", $time,
                        rsp_payload.status, rsp_payload.tokens_left);
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_payload.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           rsp_payload.status);
                  errors++;
               end
               if (rsp_payload.tokens_left !== want.tokens_left) begin
                  $display("%0t: tokens_left expected %0d actual %0d", $time,
                           want.tokens_left, rsp_payload.tokens_left);
                  errors++;
               end
            end
         end
         if (long_hold_go && !long_hold_used) begin
            long_hold_used = 1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
         $display("%0t: watchdog expired, %0d results outstanding", $time,
                  pending_rsp.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_req(req_payload_type p, bit typed, rsp_payload_type typed_rsp);
      int gap;
      rsp_payload_type got;
      gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      got = limiter_outcome(p);
      pending_rsp.push_back(typed ? typed_rsp : got);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      wait (pending_rsp.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CSR_W-1:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      if (idx == CSR_BURST_SIZE) burst_cap = val[TOKEN_W-1:0];
      else fill_rate = val[RATE_W-1:0];
   endtask

   function automatic longint unsigned next_ms();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) cur_ms = {$urandom_range(0, 16'hFFFF), $urandom} & MS_MAX;
      else if (pick == 1) return (cur_ms - $urandom_range(1, 500)) & MS_MAX;
      else cur_ms = (cur_ms + $urandom_range(0, 400)) & MS_MAX;
      return cur_ms;
   endfunction

   task automatic random_traffic(int count, int pool_n, int acq_pct, int rel_pct);
      req_payload_type p;
      int done, roll;
      done = 0;
      while (done < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) p.req_type = OP_IGNORED;
         else if (roll < 3 + acq_pct) p.req_type = OP_ACQUIRE;
         else if (roll < 3 + acq_pct + rel_pct) p.req_type = OP_RELEASE;
         else p.req_type = OP_ALLOW;
         roll = $urandom_range(0, pool_n - 1);
         p.ip_high = addr_hi[roll];
         p.ip_low = addr_lo[roll];
         p.now_ms = TIME_W'(next_ms());
         send_req(p, 0, '0);
         if (p.req_type != OP_IGNORED) done++;
         if (done == count / 3 && !long_hold_used) long_hold_go = 1;
      end
   endtask

   task automatic add_req(logic [1:0] op, int a, longint unsigned ms, logic [1:0] st,
                          logic [TOKEN_W-1:0] tk);
      row_type r;
      r = '{0, 0, '0, op, a, ms, st, tk};
      rows.push_back(r);
   endtask

   task automatic add_csr(logic idx, logic [CSR_W-1:0] val);
      row_type r;
      r = '{1, idx, val, OP_IGNORED, 0, 0, RSP_GRANTED, '0};
      rows.push_back(r);
   endtask

   initial begin
      req_payload_type p;
      rsp_payload_type t;
      for (int k = 0; k < ENT; k++) begin
         slot_used[k] = 0;
         slot_prev[k] = NO_LINK;
         slot_next[k] = NO_LINK;
      end
      addr_hi[0] = '0;
      addr_lo[0] = '0;
      addr_hi[1] = '1;
      addr_lo[1] = '1;
      for (int k = 2; k < POOL; k++) begin
         addr_hi[k] = {$urandom, $urandom};
         addr_lo[k] = {$urandom, $urandom};
      end

      add_req(OP_RELEASE, 2, 0, RSP_UNTRACKED, 0);
      add_req(OP_ALLOW, 2, 0, RSP_UNTRACKED, 0);
      add_req(OP_IGNORED, 2, 0, RSP_UNTRACKED, 0);
      add_req(OP_ACQUIRE, 2, 0, RSP_GRANTED, 64);
      add_req(OP_ALLOW, 2, 0, RSP_GRANTED, 63);
      add_req(OP_ALLOW, 2, 50, RSP_GRANTED, 62);
      add_req(OP_ALLOW, 2, 100000, RSP_GRANTED, 63);
      add_req(OP_ALLOW, 2, 5, RSP_GRANTED, 62);
      add_req(OP_RELEASE, 2, 0, RSP_GRANTED, 62);
      add_req(OP_RELEASE, 2, 0, RSP_GRANTED, 62);
      add_req(OP_ACQUIRE, 0, 0, RSP_GRANTED, 64);
      add_req(OP_ACQUIRE, 1, MS_MAX, RSP_GRANTED, 64);
      add_req(OP_ALLOW, 1, MS_MAX, RSP_GRANTED, 63);
      add_csr(CSR_BURST_SIZE, 1);
      add_csr(CSR_TOKENS_PER_SECOND, 0);
      add_req(OP_ACQUIRE, 3, 7, RSP_GRANTED, 1);
      add_req(OP_ALLOW, 3, 9, RSP_GRANTED, 0);
      add_req(OP_ALLOW, 3, MS_MAX, RSP_NO_TOKENS, 0);
      add_req(OP_ALLOW, 0, 1000, RSP_GRANTED, 63);
      add_csr(CSR_TOKENS_PER_SECOND, 20'hFFFFF);
      add_req(OP_ALLOW, 0, 1000, RSP_GRANTED, 0);
      add_req(OP_IGNORED, 3, 0, RSP_UNTRACKED, 0);

      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (rows[n]) begin
         if (rows[n].is_csr) begin
            drain();
            write_csr(rows[n].csr_idx, rows[n].csr_val);
         end else begin
            p.req_type = rows[n].op;
            p.ip_high = addr_hi[rows[n].addr];
            p.ip_low = addr_lo[rows[n].addr];
            p.now_ms = TIME_W'(rows[n].ms);
            t.status = rows[n].st;
            t.tokens_left = rows[n].tk;
            send_req(p, 1, t);
         end
      end

      drain();
      write_csr(CSR_BURST_SIZE, 64);
      write_csr(CSR_TOKENS_PER_SECOND, 10);
      cur_ms = 0;
      random_traffic(120, 12, 30, 20);
      drain();
      random_traffic(130, 12, 30, 20);

      drain();
      write_csr(CSR_BURST_SIZE, 5);
      write_csr(CSR_TOKENS_PER_SECOND, 1000);
      idle_on = 0;
      random_traffic(100, 40, 30, 20);
      idle_on = 1;
      random_traffic(150, 40, 30, 20);

      // fill the table with fresh live addresses, past the point where acquires are refused
      drain();
      write_csr(CSR_BURST_SIZE, 16'hFFFF);
      write_csr(CSR_TOKENS_PER_SECOND, 20'hFFFFF);
      for (int k = 40; k < POOL; k++) begin
         p.req_type = OP_ACQUIRE;
         p.ip_high = addr_hi[k];
         p.ip_low = addr_lo[k];
         p.now_ms = TIME_W'(next_ms());
         send_req(p, 0, '0);
      end
      random_traffic(250, POOL, 35, 40);

      drain();
      write_csr(CSR_BURST_SIZE, 0);
      write_csr(CSR_TOKENS_PER_SECOND, 0);
      idle_on = 0;
      random_traffic(100, POOL, 30, 30);

      drain();
      repeat (50) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
sv/patbl_pkg.sv
sv/patbl_ctrl.sv
sv/patbl_dpath.sv
sv/per_address_token_bucket_limiter.sv
sv/patbl_checker.sv
tb/per_address_token_bucket_limiter_test.sv
